// File: rtl/jada_pkg.sv
// ---------------------------------------------------------------------------
// jada_pkg: shared types and constants for the joystick axis debounce block
// Register map, direction codes, hold regions and interface structs.
// ---------------------------------------------------------------------------
package jada_pkg;

  localparam int SAMPLE_W = 10;
  localparam int TIME_W   = 16;
  localparam int CFG_AW   = 3;

  localparam logic [SAMPLE_W-1:0] LOW_THR_RST  = 10'd450;
  localparam logic [SAMPLE_W-1:0] HIGH_THR_RST = 10'd600;
  localparam logic [TIME_W-1:0]   DEBOUNCE_RST = 16'd20;
  localparam logic [TIME_W-1:0]   SHORT_RST    = 16'd500;
  localparam logic [TIME_W-1:0]   LONG_RST     = 16'd2000;
  localparam logic [TIME_W-1:0]   SLOW_PER_RST = 16'd200;
  localparam logic [TIME_W-1:0]   FAST_PER_RST = 16'd50;
  localparam logic [TIME_W-1:0]   TIME_MAX     = {TIME_W{1'b1}};

  typedef enum logic [CFG_AW-1:0] {
    CFG_LOW_THR  = 3'd0,
    CFG_HIGH_THR = 3'd1,
    CFG_DEBOUNCE = 3'd2,
    CFG_SHORT    = 3'd3,
    CFG_LONG     = 3'd4,
    CFG_SLOW_PER = 3'd5,
    CFG_FAST_PER = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    DIR_CENTER = 2'd0,
    DIR_UP     = 2'd1,
    DIR_DOWN   = 2'd3
  } dir_t;

  typedef enum logic [1:0] {
    REG_NONE = 2'd0,
    REG_SLOW = 2'd1,
    REG_FAST = 2'd2
  } region_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] low_thr;
    logic [SAMPLE_W-1:0] high_thr;
    logic [TIME_W-1:0]   debounce;
    logic [TIME_W-1:0]   short_hold;
    logic [TIME_W-1:0]   long_hold;
    logic [TIME_W-1:0]   slow_per;
    logic [TIME_W-1:0]   fast_per;
  } cfg_regs_t;

  typedef struct packed {
    logic hit;
    logic up;
    logic down;
    logic slow;
    logic fast;
  } evt_t;

  function automatic region_t region_of(input logic [TIME_W-1:0] t,
                                        input logic [TIME_W-1:0] short_hold,
                                        input logic [TIME_W-1:0] long_hold);
    region_t r;
    if (t > long_hold) begin
      r = REG_FAST;
    end else if (t > short_hold) begin
      r = REG_SLOW;
    end else begin
      r = REG_NONE;
    end
    return r;
  endfunction

endpackage

// File: rtl/joystick_axis_debounce_autorepeat.sv
// ---------------------------------------------------------------------------
// joystick_axis_debounce_autorepeat: joystick axis debounce with auto-repeat
// Pipeline: each input beat is held in the input register, then its result beat
//   in the result register; ticks without an event give no result beat.
// Throughput: one input beat per cycle, limited only by out_tready.
// Reset (rst_n low, synchronous): direction, timers and hold flag cleared,
//   registers restored to their defaults, both pipeline stages emptied.
// ---------------------------------------------------------------------------
module joystick_axis_debounce_autorepeat (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [9:0] sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] step_up, [1] step_down
  output logic [1:0]  out_tuser,  // [0] slow_repeat, [1] fast_repeat
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  jada_pkg::cfg_regs_t           cfg;
  jada_pkg::evt_t                evt;
  logic                          s1_valid_r, s1_valid_nxt;
  logic [jada_pkg::SAMPLE_W-1:0] s1_sample_r;
  logic                          out_valid_r, out_valid_nxt;
  logic [1:0]                    out_dir_r;
  logic [1:0]                    out_rate_r;
  logic                          advance;

  jada_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  jada_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (s1_valid_r && advance),
    .sample (s1_sample_r),
    .cfg    (cfg),
    .evt    (evt)
  );

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;

  assign s1_valid_nxt  = in_tready ? in_tvalid : s1_valid_r;
  assign out_valid_nxt = advance ? (s1_valid_r && evt.hit) : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      s1_sample_r <= in_tdata[jada_pkg::SAMPLE_W-1:0];
    end
    if (advance) begin
      out_dir_r  <= {evt.down, evt.up};
      out_rate_r <= {evt.fast, evt.slow};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_dir_r};
  assign out_tuser  = out_rate_r;

endmodule

// File: rtl/jada_cfg.sv
// ---------------------------------------------------------------------------
// jada_cfg: configuration register file
// Write-only registers for thresholds, hold times and repeat periods.
// ---------------------------------------------------------------------------
module jada_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [jada_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [jada_pkg::TIME_W-1:0]   cfg_wdata,
  output jada_pkg::cfg_regs_t           cfg
);

  jada_pkg::cfg_regs_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (jada_pkg::cfg_idx_t'(cfg_addr))
        jada_pkg::CFG_LOW_THR:  cfg_nxt.low_thr    = cfg_wdata[jada_pkg::SAMPLE_W-1:0];
        jada_pkg::CFG_HIGH_THR: cfg_nxt.high_thr   = cfg_wdata[jada_pkg::SAMPLE_W-1:0];
        jada_pkg::CFG_DEBOUNCE: cfg_nxt.debounce   = cfg_wdata;
        jada_pkg::CFG_SHORT:    cfg_nxt.short_hold = cfg_wdata;
        jada_pkg::CFG_LONG:     cfg_nxt.long_hold  = cfg_wdata;
        jada_pkg::CFG_SLOW_PER: cfg_nxt.slow_per   = cfg_wdata;
        jada_pkg::CFG_FAST_PER: cfg_nxt.fast_per   = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_thr    <= jada_pkg::LOW_THR_RST;
      cfg_r.high_thr   <= jada_pkg::HIGH_THR_RST;
      cfg_r.debounce   <= jada_pkg::DEBOUNCE_RST;
      cfg_r.short_hold <= jada_pkg::SHORT_RST;
      cfg_r.long_hold  <= jada_pkg::LONG_RST;
      cfg_r.slow_per   <= jada_pkg::SLOW_PER_RST;
      cfg_r.fast_per   <= jada_pkg::FAST_PER_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/jada_core.sv
// ---------------------------------------------------------------------------
// jada_core: direction tracking and repeat event logic
// Thresholds the sample, keeps the stable time, hold flag and repeat phase.
// ---------------------------------------------------------------------------
module jada_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fire,
  input  logic [jada_pkg::SAMPLE_W-1:0] sample,
  input  jada_pkg::cfg_regs_t           cfg,
  output jada_pkg::evt_t                evt
);

  jada_pkg::dir_t               prev_dir_r, prev_dir_nxt;
  logic [jada_pkg::TIME_W-1:0]  stable_r, stable_nxt;
  logic                         held_r, held_nxt;
  logic [jada_pkg::TIME_W-1:0]  phase_r, phase_nxt;

  jada_pkg::dir_t               dir;
  jada_pkg::region_t            reg_now, reg_before;
  logic [jada_pkg::TIME_W-1:0]  stable_inc;
  logic [jada_pkg::TIME_W-1:0]  period;
  logic [jada_pkg::TIME_W:0]    phase_sum;
  logic                         same;

  always_comb begin
    if (sample < cfg.low_thr) begin
      dir = jada_pkg::DIR_DOWN;
    end else if (sample > cfg.high_thr) begin
      dir = jada_pkg::DIR_UP;
    end else begin
      dir = jada_pkg::DIR_CENTER;
    end
  end

  assign same       = (dir == prev_dir_r);
  assign stable_inc = (stable_r == jada_pkg::TIME_MAX) ? stable_r
                                                       : stable_r + 16'd1;
  assign reg_now    = jada_pkg::region_of(stable_inc, cfg.short_hold, cfg.long_hold);
  assign reg_before = jada_pkg::region_of(stable_r, cfg.short_hold, cfg.long_hold);
  assign phase_sum  = {1'b0, phase_r} + 17'd1;

  always_comb begin
    period = (reg_now == jada_pkg::REG_FAST) ? cfg.fast_per : cfg.slow_per;
    if (period == '0) begin
      period = 16'd1;
    end
  end

  always_comb begin
    prev_dir_nxt = prev_dir_r;
    stable_nxt   = stable_r;
    held_nxt     = held_r;
    phase_nxt    = phase_r;
    evt          = '0;
    if (fire) begin
      prev_dir_nxt = dir;
      if (!same) begin
        stable_nxt = '0;
        phase_nxt  = '0;
      end else begin
        stable_nxt = stable_inc;
        if (reg_now == jada_pkg::REG_NONE) begin
          phase_nxt = '0;
        end else if (reg_now != reg_before) begin
          phase_nxt = (period <= 16'd1) ? 16'd0 : 16'd1;
        end else begin
          phase_nxt = (phase_sum >= {1'b0, period}) ? 16'd0
                                                     : phase_sum[jada_pkg::TIME_W-1:0];
        end
        if (stable_inc > cfg.debounce) begin
          if (dir != jada_pkg::DIR_CENTER) begin
            case (reg_now)
              jada_pkg::REG_FAST: begin
                evt.hit  = (phase_nxt == '0);
                evt.fast = evt.hit;
              end
              jada_pkg::REG_SLOW: begin
                evt.hit  = (phase_nxt == '0);
                evt.slow = evt.hit;
              end
              default: begin
                evt.hit  = !held_r;
                held_nxt = 1'b1;
              end
            endcase
            evt.up   = evt.hit && (dir == jada_pkg::DIR_UP);
            evt.down = evt.hit && (dir == jada_pkg::DIR_DOWN);
          end else begin
            held_nxt = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_dir_r <= jada_pkg::DIR_CENTER;
      stable_r   <= '0;
      held_r     <= 1'b0;
      phase_r    <= '0;
    end else begin
      prev_dir_r <= prev_dir_nxt;
      stable_r   <= stable_nxt;
      held_r     <= held_nxt;
      phase_r    <= phase_nxt;
    end
  end

  a_hit_one_dir: assert property (@(posedge clk) disable iff (!rst_n)
    evt.hit |-> (evt.up ^ evt.down))
    else $error("event without exactly one direction");

  a_rate_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(evt.slow && evt.fast))
    else $error("slow and fast repeat together");

  a_change_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !same) |=> (stable_r == '0 && phase_r == '0))
    else $error("direction change did not clear timers");

  a_held_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(held_r) |-> $past(evt.hit && !evt.slow && !evt.fast))
    else $error("hold flag set without a first step");

endmodule

// File: tb/joystick_step_checker.sv
// ---------------------------------------------------------------------------
// joystick_step_checker: scoreboard for the joystick axis debounce block
// Mirrors register writes and the direction, stable time, hold flag and
// repeat phase of the block. Every accepted sample beat is turned into the
// step event it should cause; step beats are compared in order against
// those events. Reports the mismatch count and the events still due.
// ---------------------------------------------------------------------------
module joystick_step_checker
  import jada_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [15:0]        in_tdata,
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [7:0]         out_tdata,
  input  logic [1:0]         out_tuser,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [15:0]        cfg_wdata,
  output int unsigned        mismatches,
  output int unsigned        pending
);

  typedef struct packed {
    logic fast;
    logic slow;
    logic down;
    logic up;
  } step_evt_t;

  cfg_regs_t         regs;
  dir_t              last_dir;
  logic [TIME_W-1:0] held_ms;
  logic [TIME_W-1:0] phase;
  logic              stepped;
  step_evt_t         step_events_due[$];
  int unsigned       bad_beats = 0;

  function automatic region_t zone(input logic [TIME_W-1:0] t);
    if (t > regs.long_hold) return REG_FAST;
    if (t > regs.short_hold) return REG_SLOW;
    return REG_NONE;
  endfunction

  task automatic tick(input logic [SAMPLE_W-1:0] s);
    dir_t              d;
    logic [TIME_W-1:0] prior;
    logic [TIME_W-1:0] per;
    region_t           zone_now;
    region_t           zone_prior;
    logic              hit;
    step_evt_t         ev;
    ev  = '0;
    hit = 1'b0;
    if (s < regs.low_thr) begin
      d = DIR_DOWN;
    end else if (s > regs.high_thr) begin
      d = DIR_UP;
    end else begin
      d = DIR_CENTER;
    end
    if (d != last_dir) begin
      held_ms = '0;
      phase   = '0;
    end else begin
      prior = held_ms;
      if (held_ms != TIME_MAX) held_ms = held_ms + 1'b1;
      zone_now   = zone(held_ms);
      zone_prior = zone(prior);
      per = (zone_now == REG_FAST) ? regs.fast_per : regs.slow_per;
      if (per == '0) per = 16'd1;
      if (zone_now == REG_NONE) begin
        phase = '0;
      end else if (zone_now != zone_prior) begin
        phase = (per <= 16'd1) ? 16'd0 : 16'd1;
      end else if (17'(phase) + 17'd1 >= 17'(per)) begin
        phase = '0;
      end else begin
        phase = phase + 1'b1;
      end
      if (held_ms > regs.debounce) begin
        if (d != DIR_CENTER) begin
          if (zone_now == REG_FAST) begin
            if (phase == '0) begin
              hit     = 1'b1;
              ev.fast = 1'b1;
            end
          end else if (zone_now == REG_SLOW) begin
            if (phase == '0) begin
              hit     = 1'b1;
              ev.slow = 1'b1;
            end
          end else if (!stepped) begin
            hit     = 1'b1;
            stepped = 1'b1;
          end
          if (hit) begin
            if (d == DIR_UP) ev.up = 1'b1;
            else ev.down = 1'b1;
          end
        end else begin
          stepped = 1'b0;
        end
      end
    end
    last_dir = d;
    if (hit) step_events_due.push_back(ev);
  endtask

  always @(posedge clk) begin
    step_evt_t want;
    if (!rst_n) begin
      regs = '{low_thr: LOW_THR_RST, high_thr: HIGH_THR_RST, debounce: DEBOUNCE_RST,
               short_hold: SHORT_RST, long_hold: LONG_RST, slow_per: SLOW_PER_RST,
               fast_per: FAST_PER_RST};
      last_dir = DIR_CENTER;
      held_ms  = '0;
      phase    = '0;
      stepped  = 1'b0;
      step_events_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (step_events_due.size() == 0) begin
          bad_beats = bad_beats + 1;
          if (bad_beats <= 10)
            $display("unexpected step beat: tdata %h tuser %b", out_tdata, out_tuser);
        end else begin
          want = step_events_due.pop_front();
          if (out_tdata !== {6'b0, want.down, want.up} ||
              out_tuser !== {want.fast, want.slow}) begin
            bad_beats = bad_beats + 1;
            if (bad_beats <= 10)
              $display("step mismatch: expected tdata %h tuser %b, got tdata %h tuser %b",
                       {6'b0, want.down, want.up}, {want.fast, want.slow},
                       out_tdata, out_tuser);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_LOW_THR:  regs.low_thr    = cfg_wdata[SAMPLE_W-1:0];
          CFG_HIGH_THR: regs.high_thr   = cfg_wdata[SAMPLE_W-1:0];
          CFG_DEBOUNCE: regs.debounce   = cfg_wdata;
          CFG_SHORT:    regs.short_hold = cfg_wdata;
          CFG_LONG:     regs.long_hold  = cfg_wdata;
          CFG_SLOW_PER: regs.slow_per   = cfg_wdata;
          CFG_FAST_PER: regs.fast_per   = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) tick(in_tdata[SAMPLE_W-1:0]);
    end
    mismatches <= bad_beats;
    pending    <= step_events_due.size();
  end

endmodule

// File: tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench: joystick axis debounce with auto-repeat
// Directed runs over thresholds, debounce, hold regions and period changes,
// then random direction runs with noise under several register settings and
// sender/receiver idling mixes.
// ---------------------------------------------------------------------------
module testbench;
  import jada_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;    // [9:0] sample
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;   // [0] step_up, [1] step_down
  logic [1:0]  out_tuser;   // [0] slow_repeat, [1] fast_repeat
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [15:0] cfg_wdata;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  cfg_regs_t   cur_cfg;

  joystick_axis_debounce_autorepeat dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  joystick_step_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  always @(posedge clk) begin
    if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic push_sample(input logic [SAMPLE_W-1:0] s);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 16'($urandom_range(1023));
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, s};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic hold(input logic [SAMPLE_W-1:0] s, input int n);
    repeat (n) push_sample(s);
  endtask

  // drain every due step beat, then let the pipeline empty
  task automatic settle();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t a, input logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_addr  <= a;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  task automatic load_cfg(input cfg_regs_t c);
    cur_cfg = c;
    write_reg(CFG_LOW_THR, 16'(c.low_thr));
    write_reg(CFG_HIGH_THR, 16'(c.high_thr));
    write_reg(CFG_DEBOUNCE, c.debounce);
    write_reg(CFG_SHORT, c.short_hold);
    write_reg(CFG_LONG, c.long_hold);
    write_reg(CFG_SLOW_PER, c.slow_per);
    write_reg(CFG_FAST_PER, c.fast_per);
    cfg_we <= 1'b0;
  endtask

  function automatic cfg_regs_t rand_setting();
    cfg_regs_t c;
    c.low_thr  = 10'($urandom_range(500, 100));
    c.high_thr = 10'($urandom_range(950, 520));
    case ($urandom_range(7))
      0: begin
        c.low_thr  = 10'($urandom_range(1023, 600));
        c.high_thr = 10'($urandom_range(400, 0));
      end
      1: begin
        c.low_thr  = '0;
        c.high_thr = 10'($urandom_range(1023, 900));
      end
      default: ;
    endcase
    c.debounce   = 16'($urandom_range(4, 0));
    c.short_hold = 16'($urandom_range(12, 0));
    if ($urandom_range(7) == 0) begin
      c.long_hold = 16'($urandom_range(int'(c.short_hold), 0));
    end else begin
      c.long_hold = c.short_hold + 16'($urandom_range(20, 0));
    end
    c.slow_per = 16'($urandom_range(6, 0));
    c.fast_per = 16'($urandom_range(4, 0));
    return c;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick(input dir_t d, input cfg_regs_t c);
    int lo;
    case (d)
      DIR_DOWN: begin
        if (c.low_thr != '0) return 10'($urandom_range(int'(c.low_thr) - 1, 0));
      end
      DIR_UP: begin
        lo = int'(c.high_thr) + 1;
        if (int'(c.low_thr) > lo) lo = int'(c.low_thr);
        if (lo <= 1023) return 10'($urandom_range(1023, lo));
      end
      default: begin
        if (c.low_thr <= c.high_thr)
          return 10'($urandom_range(int'(c.high_thr), int'(c.low_thr)));
      end
    endcase
    return 10'($urandom_range(1023));
  endfunction

  // mostly steady direction runs, some short glitches and raw noise
  task automatic random_runs(input int quota);
    int   done;
    int   len;
    int   k;
    dir_t d;
    done = 0;
    while (done < quota) begin
      k = $urandom_range(99);
      if (k < 15) begin
        len = $urandom_range(5, 1);
        repeat (len) push_sample(10'($urandom_range(1023)));
      end else begin
        case ($urandom_range(2))
          0: d = DIR_CENTER;
          1: d = DIR_UP;
          default: d = DIR_DOWN;
        endcase
        len = (k < 35) ? $urandom_range(3, 1) :
                         $urandom_range(int'(cur_cfg.long_hold) + 12, 1);
        repeat (len) push_sample(pick(d, cur_cfg));
      end
      done += len;
    end
  endtask

  initial begin
    cfg_regs_t c;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= CFG_LOW_THR;
    cfg_wdata <= '0;
    cur_cfg = '{low_thr: LOW_THR_RST, high_thr: HIGH_THR_RST, debounce: DEBOUNCE_RST,
                short_hold: SHORT_RST, long_hold: LONG_RST, slow_per: SLOW_PER_RST,
                fast_per: FAST_PER_RST};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults: everything stays inside the debounce window
    hold(10'd1023, 3);
    hold(10'd0, 3);
    hold(10'd525, 2);
    settle();

    // first step, slow and fast repeats, reversal, release and boundaries
    c = '{low_thr: 10'd450, high_thr: 10'd600, debounce: 16'd2, short_hold: 16'd4,
          long_hold: 16'd8, slow_per: 16'd3, fast_per: 16'd2};
    load_cfg(c);
    hold(10'd1023, 12);
    hold(10'd0, 5);
    hold(10'd525, 4);
    hold(10'd601, 4);
    hold(10'd449, 2);
    hold(10'd450, 1);
    hold(10'd600, 1);
    settle();

    // fast period lowered below the running phase
    c = '{low_thr: 10'd450, high_thr: 10'd600, debounce: 16'd0, short_hold: 16'd2,
          long_hold: 16'd3, slow_per: 16'd0, fast_per: 16'd40};
    load_cfg(c);
    hold(10'd1023, 20);
    settle();
    c.fast_per = 16'd5;
    load_cfg(c);
    hold(10'd1023, 6);
    settle();

    // thresholds at the rails, then crossed
    c = '{low_thr: 10'd0, high_thr: 10'd1023, debounce: 16'd0, short_hold: 16'd0,
          long_hold: 16'd1, slow_per: 16'd1, fast_per: 16'd0};
    load_cfg(c);
    hold(10'd0, 3);
    hold(10'd1023, 3);
    settle();
    c = '{low_thr: 10'd1023, high_thr: 10'd0, debounce: 16'd0, short_hold: 16'd0,
          long_hold: 16'd65535, slow_per: 16'd0, fast_per: 16'd1};
    load_cfg(c);
    hold(10'd1022, 3);
    hold(10'd1023, 3);
    hold(10'd0, 2);
    settle();

    // debounce never satisfied
    c = '{low_thr: 10'd450, high_thr: 10'd600, debounce: 16'd65535, short_hold: 16'd0,
          long_hold: 16'd1, slow_per: 16'd1, fast_per: 16'd1};
    load_cfg(c);
    hold(10'd1023, 5);
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 64; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 64; end
        default: begin send_idle_pct = 20; stall_pct = 20; end
      endcase
      for (int s = 0; s < 2; s++) begin
        load_cfg(rand_setting());
        random_runs(125);
        settle();
      end
    end

    if (mismatches == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/jada_pkg.sv
rtl/jada_cfg.sv
rtl/jada_core.sv
rtl/joystick_axis_debounce_autorepeat.sv
tb/joystick_step_checker.sv
tb/testbench.sv
